// File: hw/rtl/bumpa_pkg.sv
// Shared types and codes for the bump allocator with exact-size reuse.
// No dependencies; used by bump_allocator_size_reuse_core, bumpa_alloc_checker and the testbench top.
package bumpa_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CARVE,
        ST_DONE
    } state_t;

    // Request kinds carried on tuser
    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_UNKNOWN  = 2'd3
    } status_t;

    // Region start after reset
    localparam logic [31:0] RESET_BASE = 32'h2000_0000;

    // Result payload width, padded to whole bytes
    localparam int unsigned OUT_DATA_W = 72;

endpackage

// File: hw/rtl/bumpa_table.sv
// Block table store: one size and one address per slot, synchronous read.
// Depends on nothing; instantiated by bump_allocator_size_reuse_core.
module bumpa_table #(
    parameter int TABLE_ENTRIES = 8,
    parameter int ADDR_BITS     = 32
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_idx,
    input  logic [31:0]                                wr_size,
    input  logic [ADDR_BITS-1:0]                       wr_addr,
    input  logic                                       rd_en,
    input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_idx,
    output logic [31:0]                                rd_size,
    output logic [ADDR_BITS-1:0]                       rd_addr
);

    localparam int ENTRY_W = 32 + ADDR_BITS;

    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_size, wr_addr};
        end
    end

    // Read one slot; the data is registered and appears in the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_size = rd_data_reg[ENTRY_W-1:ADDR_BITS];
    assign rd_addr = rd_data_reg[ADDR_BITS-1:0];

endmodule

// File: hw/rtl/bump_allocator_size_reuse_core.sv
// Top level of the bump allocator with exact-size reuse.
// Depends on bumpa_pkg and bumpa_table.
//
//  channel   direction  payload (low bit first)
//  s_axis    in         tdata: alloc_size[31:0], free_address[63:32]; tuser: func
//  m_axis    out        tdata: block_address[31:0], status[33:32],
//                              bytes_reserved[65:34], zero fill[71:66]
//  cfg       in         cfg_wr_data: region_base
//
// One transaction at a time. The table is scanned one slot per cycle through the
// single read port of the table store, whose read data is registered; a request
// goes from ST_SCAN to ST_DONE, and an allocate that misses passes through ST_CARVE
// between them to carve and record the new block.
// Reset clears the valid state at once (fill count and busy flags); no clearing pass.
// A new request is taken while a result still waits on m_axis; the next result
// holds in its sequencer until the output register is free.
module bump_allocator_size_reuse_core #(
    parameter int TABLE_ENTRIES = 8,
    parameter int ADDR_BITS     = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [31:0]                           cfg_wr_data,   // region_base
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [63:0]                           s_axis_tdata,  // alloc_size, free_address
    input  logic [0:0]                            s_axis_tuser,  // func
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [bumpa_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // block_address, status,
                                                                 // bytes_reserved, zero fill
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    bumpa_pkg::state_t state_reg, state_next;

    // Control state
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         issue_idx_reg, issue_idx_next;
    logic                     pend_reg, pend_next;
    logic [TABLE_ENTRIES-1:0] busy_reg, busy_next;
    logic [ADDR_BITS-1:0]     next_free_reg, next_free_next;
    logic [31:0]              total_reg, total_next;
    logic                     out_valid_reg, out_valid_next;

    // Payload state
    bumpa_pkg::func_t          req_func_reg, req_func_next;
    logic [31:0]               req_size_reg, req_size_next;
    logic [31:0]               req_faddr_reg, req_faddr_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic [ADDR_BITS-1:0]      res_addr_reg, res_addr_next;
    bumpa_pkg::status_t        res_status_reg, res_status_next;
    logic [bumpa_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Table store ports
    logic                 tbl_wr_en;
    logic                 tbl_rd_en;
    logic [31:0]          rd_size;
    logic [ADDR_BITS-1:0] rd_addr;

    // Datapath helpers
    logic                 entry_hit;
    logic                 table_full;
    logic [CMP_W:0]       carve_sum;
    logic                 addr_ovf;
    logic [32:0]          total_sum;
    logic [CMP_W-1:0]     res_addr_ext;

    bumpa_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_idx  (count_reg[IDX_W-1:0]),
        .wr_size (req_size_reg),
        .wr_addr (next_free_reg),
        .rd_en   (tbl_rd_en),
        .rd_idx  (issue_idx_reg[IDX_W-1:0]),
        .rd_size (rd_size),
        .rd_addr (rd_addr)
    );

    // Compare the slot read back last cycle
    always_comb
    begin
        if (req_func_reg == bumpa_pkg::FUNC_FREE)
        begin
            entry_hit = pend_reg && (CMP_W'(rd_addr) == CMP_W'(req_faddr_reg));
        end
        else
        begin
            entry_hit = pend_reg && !busy_reg[pend_idx_reg] && (rd_size == req_size_reg);
        end
    end

    // Carve checks: table space, address top, saturating byte total
    assign table_full   = (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign carve_sum    = (CMP_W + 1)'(next_free_reg) + (CMP_W + 1)'(req_size_reg);
    assign addr_ovf     = |carve_sum[CMP_W:ADDR_BITS];
    assign total_sum    = {1'b0, total_reg} + {1'b0, req_size_reg};
    assign res_addr_ext = CMP_W'(res_addr_reg);

    assign tbl_rd_en = (state_reg == bumpa_pkg::ST_SCAN) && (issue_idx_reg < count_reg);
    assign tbl_wr_en = (state_reg == bumpa_pkg::ST_CARVE) && !table_full && !addr_ovf;

    assign s_axis_tready = (state_reg == bumpa_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_idx_next  = issue_idx_reg;
        pend_next       = pend_reg;
        busy_next       = busy_reg;
        next_free_next  = next_free_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        req_func_next   = req_func_reg;
        req_size_next   = req_size_reg;
        req_faddr_next  = req_faddr_reg;
        pend_idx_next   = pend_idx_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;

        // Drop the output once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Reload the pointer on a base write while nothing is carved
        if (cfg_wr_en && (count_reg == '0))
        begin
            next_free_next = ADDR_BITS'(cfg_wr_data);
        end

        case (state_reg)
            bumpa_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_func_next  = bumpa_pkg::func_t'(s_axis_tuser[0]);
                    req_size_next  = s_axis_tdata[31:0];
                    req_faddr_next = s_axis_tdata[63:32];
                    issue_idx_next = '0;
                    pend_next      = 1'b0;
                    state_next     = bumpa_pkg::ST_SCAN;
                end
            end

            bumpa_pkg::ST_SCAN:
            begin
                // Advance the read pointer and track the slot in flight
                pend_next     = tbl_rd_en;
                pend_idx_next = issue_idx_reg[IDX_W-1:0];
                if (tbl_rd_en)
                begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end

                if (entry_hit)
                begin
                    pend_next  = 1'b0;
                    state_next = bumpa_pkg::ST_DONE;
                    res_status_next = bumpa_pkg::STATUS_OK;
                    if (req_func_reg == bumpa_pkg::FUNC_FREE)
                    begin
                        busy_next[pend_idx_reg] = 1'b0;
                        res_addr_next           = '0;
                    end
                    else
                    begin
                        busy_next[pend_idx_reg] = 1'b1;
                        res_addr_next           = rd_addr;
                    end
                end
                else if (!pend_reg && !tbl_rd_en)
                begin
                    // Scan exhausted
                    if (req_func_reg == bumpa_pkg::FUNC_FREE)
                    begin
                        res_addr_next   = '0;
                        res_status_next = bumpa_pkg::STATUS_UNKNOWN;
                        state_next      = bumpa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bumpa_pkg::ST_CARVE;
                    end
                end
            end

            bumpa_pkg::ST_CARVE:
            begin
                res_addr_next = '0;
                if (table_full)
                begin
                    res_status_next = bumpa_pkg::STATUS_FULL;
                end
                else if (addr_ovf)
                begin
                    res_status_next = bumpa_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    // Record the new block and bump the pointer
                    res_addr_next   = next_free_reg;
                    res_status_next = bumpa_pkg::STATUS_OK;
                    busy_next[count_reg[IDX_W-1:0]] = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    next_free_next  = carve_sum[ADDR_BITS-1:0];
                    total_next      = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
                end
                state_next = bumpa_pkg::ST_DONE;
            end

            bumpa_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, total_reg, res_status_reg, res_addr_ext[31:0]};
                    state_next     = bumpa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bumpa_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bumpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            issue_idx_reg   <= '0;
            pend_reg        <= 1'b0;
            busy_reg        <= '0;
            next_free_reg   <= ADDR_BITS'(bumpa_pkg::RESET_BASE);
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            pend_reg      <= pend_next;
            busy_reg      <= busy_next;
            next_free_reg <= next_free_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_func_reg   <= req_func_next;
        req_size_reg   <= req_size_next;
        req_faddr_reg  <= req_faddr_next;
        pend_idx_reg   <= pend_idx_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

endmodule

// File: tb/bumpa_alloc_checker.sv
`timescale 1ns / 100ps
// Checker for bump_allocator_size_reuse_core: keeps its own copy of the block table,
// predicts one result per accepted request and compares every m_axis transaction.
// Depends on bumpa_pkg.
module bumpa_alloc_checker #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [31:0]                      cfg_wr_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [63:0]                      s_axis_tdata,
    input  logic [0:0]                       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [bumpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                               mismatches,
    output int                               outstanding
);

    // One predicted grant as it should appear on m_axis
    typedef struct packed {
        logic [31:0]        address;
        bumpa_pkg::status_t status;
        logic [31:0]        reserved;
    } grant_t;

    logic        slot_used [TABLE_ENTRIES];
    logic        slot_busy [TABLE_ENTRIES];
    logic [31:0] slot_size [TABLE_ENTRIES];
    logic [31:0] slot_addr [TABLE_ENTRIES];
    logic [31:0] bump_ptr;
    int unsigned slot_count;
    logic [31:0] carved_total;
    grant_t      grant_q [$];
    int          err_count;

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        err_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    endtask

    // Work out the grant for one request and update the mirrored table
    task automatic predict_grant(input bumpa_pkg::func_t kind, input logic [31:0] size,
                                 input logic [31:0] faddr, output grant_t g);
        int          i;
        int          hit;
        logic [32:0] reach;
        logic [32:0] sum;
        g   = '{address: 32'd0, status: bumpa_pkg::STATUS_OK, reserved: 32'd0};
        hit = -1;
        if (kind == bumpa_pkg::FUNC_FREE)
        begin
            // lowest-indexed recorded entry with that address, busy or not
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (hit < 0 && slot_used[i] && slot_addr[i] == faddr)
                    hit = i;
            if (hit >= 0)
                slot_busy[hit] = 1'b0;
            else
                g.status = bumpa_pkg::STATUS_UNKNOWN;
        end
        else
        begin
            // exact-size reuse of a free entry comes first
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (hit < 0 && slot_used[i] && !slot_busy[i] && slot_size[i] == size)
                    hit = i;
            reach = {1'b0, bump_ptr} + {1'b0, size};
            if (hit >= 0)
            begin
                slot_busy[hit] = 1'b1;
                g.address      = slot_addr[hit];
            end
            else if (slot_count >= TABLE_ENTRIES)
                g.status = bumpa_pkg::STATUS_FULL;
            else if (reach[32])
                g.status = bumpa_pkg::STATUS_OVERFLOW;
            else
            begin
                // carve at the bump pointer and append an entry
                slot_used[slot_count] = 1'b1;
                slot_busy[slot_count] = 1'b1;
                slot_size[slot_count] = size;
                slot_addr[slot_count] = bump_ptr;
                slot_count++;
                g.address    = bump_ptr;
                bump_ptr     = reach[31:0];
                sum          = {1'b0, carved_total} + {1'b0, size};
                carved_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
        end
        g.reserved = carved_total;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t got;
        int     i;
        if (!rst_n)
        begin
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_busy[i] = 1'b0;
            end
            bump_ptr     = bumpa_pkg::RESET_BASE;
            slot_count   = 0;
            carved_total = 32'd0;
            grant_q.delete();
            err_count    = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // compare a result transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grant_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result with nothing expected, expected none actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.address)
                        report_field("block_address", want.address, m_axis_tdata[31:0]);
                    if (m_axis_tdata[33:32] !== want.status)
                        report_field("status", 32'(want.status), 32'(m_axis_tdata[33:32]));
                    if (m_axis_tdata[65:34] !== want.reserved)
                        report_field("bytes_reserved", want.reserved, m_axis_tdata[65:34]);
                end
            end
            // region base: reload the pointer only before any carve
            if (cfg_wr_en)
            begin
                if (slot_count == 0)
                    bump_ptr = cfg_wr_data;
            end
            // predict for an accepted request transaction
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_grant(bumpa_pkg::func_t'(s_axis_tuser[0]), s_axis_tdata[31:0],
                              s_axis_tdata[63:32], got);
                grant_q.push_back(got);
            end
            mismatches  <= err_count;
            outstanding <= grant_q.size();
        end
    end

endmodule

// File: tb/tb_bump_allocator_size_reuse_core.sv
`timescale 1ns / 100ps
// Testbench top for bump_allocator_size_reuse_core: drives requests and region base
// writes with random pauses and stalls; bumpa_alloc_checker judges the results.
// Depends on bumpa_pkg, bumpa_alloc_checker and the block RTL.
module tb_bump_allocator_size_reuse_core;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 175;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [31:0]           cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;  // alloc_size, free_address
    logic [0:0]            s_axis_tuser;  // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [bumpa_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // block_address, status,
                                                     // bytes_reserved, zero fill
    int                    mismatches;
    int                    outstanding;
    int                    cycle_count = 0;
    bit                    quiet = 1'b0;
    logic [31:0]           seen_addr [$];
    logic [31:0]           size_menu [7] = '{32'd0, 32'd1, 32'd4, 32'h10, 32'h40,
                                             32'h100, 32'h1000};
    logic [31:0]           base_menu [3] = '{bumpa_pkg::RESET_BASE, 32'hFFFF_FFFF, 32'h0};

    bump_allocator_size_reuse_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bumpa_alloc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb_bump_allocator_size_reuse_core failed");
            $finish;
        end
    end

    // Collect granted addresses so that frees mostly hit recorded blocks
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready
            && m_axis_tdata[33:32] == bumpa_pkg::STATUS_OK
            && m_axis_tdata[31:0] != 32'd0)
        begin
            seen_addr.push_back(m_axis_tdata[31:0]);
            if (seen_addr.size() > 24)
                void'(seen_addr.pop_front());
        end
    end

    function automatic int draw_pause();
        return quiet ? 0 : int'($urandom_range(0, 18));
    endfunction

    // Offer one request transaction and hold it until it is taken
    task automatic send_request(input bumpa_pkg::func_t kind, input logic [31:0] size,
                                input logic [31:0] faddr);
        int pause;
        pause = draw_pause();
        if (pause > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {faddr, size};
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly sizes from a short menu so that reuse and table full occur often
    task automatic random_request();
        bumpa_pkg::func_t kind;
        logic [31:0]      size;
        logic [31:0]      faddr;
        int               pick;
        kind = ($urandom_range(0, 9) < 7) ? bumpa_pkg::FUNC_ALLOC : bumpa_pkg::FUNC_FREE;
        pick = $urandom_range(0, 19);
        if (pick < 16)
            size = size_menu[$urandom_range(0, 6)];
        else if (pick < 19)
            size = $urandom();
        else
            size = 32'hFFFF_FFFF;
        if (seen_addr.size() > 0 && $urandom_range(0, 9) < 7)
            faddr = seen_addr[$urandom_range(0, seen_addr.size() - 1)];
        else if ($urandom_range(0, 9) == 0)
            faddr = 32'd0;
        else
            faddr = $urandom();
        send_request(kind, size, faddr);
    endtask

    // Result side: stall at random before each transaction
    initial
    begin
        int pause;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            pause = draw_pause();
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        int phase;
        int n;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 64'd0;
        s_axis_tuser  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Base at the top address: any non-zero size overflows, frees are unknown
        write_base(32'hFFFF_FFFF);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'd1, 32'h0);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(bumpa_pkg::FUNC_FREE, 32'hFFFF_FFFF, 32'h2000_0000);
        drain();

        // Base at zero: zero size, shared address, double free, reuse
        write_base(32'h0);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'd0, 32'hA5A5_A5A5);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'h10, 32'h0);
        send_request(bumpa_pkg::FUNC_FREE, 32'h0, 32'h0);
        send_request(bumpa_pkg::FUNC_FREE, 32'h5A5A_5A5A, 32'h0);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'h10, 32'h0);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'd0, 32'h0);
        send_request(bumpa_pkg::FUNC_FREE, 32'h0, 32'h10);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'h10, 32'h0);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 32'h0);
        send_request(bumpa_pkg::FUNC_FREE, 32'h0, 32'h5555_AAAA);
        send_request(bumpa_pkg::FUNC_FREE, 32'h0, 32'hFFFF_FFFF);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'h40, 32'hFFFF_FFFF);
        send_request(bumpa_pkg::FUNC_FREE, 32'hFFFF_FFFF, 32'h20);
        send_request(bumpa_pkg::FUNC_ALLOC, 32'h40, 32'h0);
        drain();

        // Random phases; later base writes come after blocks are carved and leave the pointer alone
        for (phase = 0; phase < 4; phase++)
        begin
            write_base(phase == 3 ? $urandom() : base_menu[phase]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                random_request();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_bump_allocator_size_reuse_core passed");
        else
            $display("tb_bump_allocator_size_reuse_core failed");
        $finish;
    end

endmodule
